// ===== src/fbpa_pkg.sv =====
// Package for the fixed-block pool allocator: widths, pool size,
// operation and status codes, controller state type. No dependencies.
package fbpa_pkg;

    localparam int POOL_BLOCKS = 256;
    localparam int PTR_W       = $clog2(POOL_BLOCKS);
    localparam int CNT_W       = $clog2(POOL_BLOCKS + 1);
    localparam int INDEX_W     = 8;
    localparam int BYTES_W     = 16;
    localparam int OFFSET_W    = 24;
    localparam int STATUS_W    = 2;

    localparam logic OP_ALLOC  = 1'b0;
    localparam logic OP_RETURN = 1'b1;

    localparam logic [15:0] BLOCK_BYTES_RESET = 16'd64;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

endpackage

// ===== src/fbpa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/fixed_block_pool_allocator.sv =====
// Fixed-block pool allocator, top level. Free list is a FIFO ring in
// fbpa_ram; uses fbpa_pkg for widths and codes.
//
// Timing: an accepted command moves the controller to S_READ while the ring
// read is registered; the result registers and done are loaded from S_READ.
// A new command is taken only back in S_IDLE, as busy is high for the cycle
// after acceptance. Results cannot be stalled; done marks them for one cycle.
// Reset (rst_n low, async) restores the ring to index i at entry i through
// per-entry valid bits, so no clearing pass is needed; block_bytes resets to 64.
module fixed_block_pool_allocator (
    input  logic                             clk,
    input  logic                             rst_n,
    // command
    input  logic                             start,
    output logic                             busy,
    input  logic                             operation,
    input  logic [fbpa_pkg::INDEX_W-1:0]     block_index,
    // result
    output logic                             done,
    output logic [fbpa_pkg::INDEX_W-1:0]     granted_index,
    output logic [fbpa_pkg::OFFSET_W-1:0]    byte_offset,
    output logic [fbpa_pkg::STATUS_W-1:0]    status,
    output logic [fbpa_pkg::CNT_W-1:0]       free_count,
    output logic [fbpa_pkg::CNT_W-1:0]       low_watermark,
    // configuration
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fbpa_pkg::BYTES_W-1:0]     cfg_data
);

    fbpa_pkg::state_t                   state_reg, state_next;
    logic [fbpa_pkg::PTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [fbpa_pkg::PTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [fbpa_pkg::CNT_W-1:0]         free_reg, free_next;
    logic [fbpa_pkg::CNT_W-1:0]         lowest_reg, lowest_next;
    logic [fbpa_pkg::POOL_BLOCKS-1:0]   valid_reg;
    logic [fbpa_pkg::BYTES_W-1:0]       block_bytes_reg;

    // captured at acceptance, used when ring data returns
    logic                               grant_reg;
    logic                               rd_valid_reg;
    logic [fbpa_pkg::PTR_W-1:0]         rd_addr_reg;
    fbpa_pkg::status_t                  status_reg, status_next;

    // result registers
    logic                               done_reg;
    logic [fbpa_pkg::INDEX_W-1:0]       granted_reg;
    logic [fbpa_pkg::OFFSET_W-1:0]      offset_reg;
    fbpa_pkg::status_t                  res_status_reg;

    logic                               accept;
    logic                               do_alloc;
    logic                               do_return;
    logic                               ring_we;
    logic [fbpa_pkg::INDEX_W-1:0]       ring_q;
    logic [fbpa_pkg::INDEX_W-1:0]       grant_idx;
    logic [fbpa_pkg::OFFSET_W-1:0]      product;

    assign busy      = (state_reg != fbpa_pkg::S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // Empty/full decided from the count; failed commands leave pointers and count alone.
    assign do_alloc  = accept && (operation == fbpa_pkg::OP_ALLOC) && (free_reg != '0);
    assign do_return = accept && (operation == fbpa_pkg::OP_RETURN)
                       && (free_reg < fbpa_pkg::CNT_W'(fbpa_pkg::POOL_BLOCKS));
    assign ring_we   = do_return;

    fbpa_ram #(
        .WIDTH (fbpa_pkg::INDEX_W),
        .DEPTH (fbpa_pkg::POOL_BLOCKS)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (wr_ptr_reg),
        .wdata (block_index),
        .raddr (rd_ptr_reg),
        .rdata (ring_q)
    );

    always_comb
    begin
        state_next  = state_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        free_next   = free_reg;
        lowest_next = lowest_reg;
        status_next = fbpa_pkg::ST_OK;

        unique case (state_reg)
            fbpa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = fbpa_pkg::S_READ;
                end
            end
            fbpa_pkg::S_READ:
            begin
                state_next = fbpa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = fbpa_pkg::S_IDLE;
            end
        endcase

        if (accept && (operation == fbpa_pkg::OP_ALLOC) && !do_alloc)
        begin
            status_next = fbpa_pkg::ST_EXHAUSTED;
        end
        if (accept && (operation == fbpa_pkg::OP_RETURN) && !do_return)
        begin
            status_next = fbpa_pkg::ST_FULL;
        end

        if (do_alloc)
        begin
            rd_ptr_next = (rd_ptr_reg == fbpa_pkg::PTR_W'(fbpa_pkg::POOL_BLOCKS - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
            free_next   = free_reg - 1'b1;
            if (free_next < lowest_reg)
            begin
                lowest_next = free_next;
            end
        end

        if (do_return)
        begin
            wr_ptr_next = (wr_ptr_reg == fbpa_pkg::PTR_W'(fbpa_pkg::POOL_BLOCKS - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
            free_next   = free_reg + 1'b1;
        end
    end

    // Entries never written since reset read as their own address.
    assign grant_idx = grant_reg
                       ? (rd_valid_reg ? ring_q : fbpa_pkg::INDEX_W'(rd_addr_reg))
                       : '0;
    assign product   = fbpa_pkg::OFFSET_W'(grant_idx) * fbpa_pkg::OFFSET_W'(block_bytes_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fbpa_pkg::S_IDLE;
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            free_reg        <= fbpa_pkg::CNT_W'(fbpa_pkg::POOL_BLOCKS);
            lowest_reg      <= fbpa_pkg::CNT_W'(fbpa_pkg::POOL_BLOCKS);
            valid_reg       <= '0;
            block_bytes_reg <= fbpa_pkg::BLOCK_BYTES_RESET;
            grant_reg       <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            free_reg   <= free_next;
            lowest_reg <= lowest_next;
            if (ring_we)
            begin
                valid_reg[wr_ptr_reg] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                block_bytes_reg <= cfg_data;
            end
            if (accept)
            begin
                grant_reg <= do_alloc;
            end
            done_reg <= (state_reg == fbpa_pkg::S_READ);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_valid_reg <= valid_reg[rd_ptr_reg];
            rd_addr_reg  <= rd_ptr_reg;
            status_reg   <= status_next;
        end
        if (state_reg == fbpa_pkg::S_READ)
        begin
            granted_reg    <= grant_idx;
            offset_reg     <= product;
            res_status_reg <= status_reg;
        end
    end

    assign done          = done_reg;
    assign granted_index = granted_reg;
    assign byte_offset   = offset_reg;
    assign status        = res_status_reg;
    assign free_count    = free_reg;
    assign low_watermark = lowest_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= fbpa_pkg::CNT_W'(fbpa_pkg::POOL_BLOCKS))
        else $error("free count above pool size");

    a_watermark: assert property (@(posedge clk) disable iff (!rst_n)
        lowest_reg <= free_reg)
        else $error("low watermark above free count");

    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == fbpa_pkg::S_READ) ##1 done_reg)
        else $error("accepted command did not complete in two cycles");

    a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (res_status_reg != fbpa_pkg::ST_OK))
        |-> (granted_reg == '0) && (offset_reg == '0))
        else $error("failed command reported a grant");

    a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("empty ring with unequal pointers");

endmodule
